>>> rtl/tksc_pkg.sv
package tksc_pkg;

  localparam int SmallSlotsDef = 8;
  localparam int BigSlotsDef   = 2;

  localparam int IdW  = 16;
  localparam int LenW = 13;

  // Request kinds
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_LOOKUP = 3'd1;
  localparam logic [2:0] KIND_EVICT  = 3'd2;
  localparam logic [2:0] KIND_COMMIT = 3'd3;
  localparam logic [2:0] KIND_CLAIM  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADARGS  = 2'd1;
  localparam logic [1:0] ST_NOSPACE  = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Register indexes
  localparam logic REG_SMALL_LIMIT = 1'b0;
  localparam logic REG_BIG_LIMIT   = 1'b1;

  localparam logic [LenW-1:0] SmallLimitRst = 13'd256;
  localparam logic [LenW-1:0] BigLimitRst   = 13'd1024;

  // One slot entry as held in a tier memory
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [LenW-1:0] len;
    logic            com;
  } slot_t;

endpackage

>>> rtl/two_tier_key_slot_cache_top.sv
// One request at a time: the next word is accepted the cycle after the previous
// result has moved to the output register. Each request is worked by scan passes
// over the slot memories, one entry read per cycle.
// Reset: synchronous, active low; all slots read as erased, limits 256 and 1024.
module two_tier_key_slot_cache_top
  import tksc_pkg::*;
#(
  parameter int SMALL_SLOTS = SmallSlotsDef,
  parameter int BIG_SLOTS   = BigSlotsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // key_id[15:0], key_len[28:16], in_nvm[29]
  input  logic [31:0] in_tdata,
  // kind[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], in_big_cache[2], slot_index[5:3], stored_len[18:6], slot_committed[19]
  output logic [23:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SAW = (SMALL_SLOTS > 1) ? $clog2(SMALL_SLOTS) : 1;
  localparam int BAW = (BIG_SLOTS > 1) ? $clog2(BIG_SLOTS) : 1;
  localparam int CW  = ((SMALL_SLOTS > BIG_SLOTS) ? $clog2(SMALL_SLOTS + 1)
                                                  : $clog2(BIG_SLOTS + 1));

  typedef enum logic [2:0] {
    S_IDLE, S_DUP, S_FREE, S_COM, S_FIND, S_DONE
  } state_t;

  state_t          state_r;
  logic [2:0]      kind_r;
  logic [IdW-1:0]  id_r;
  logic [LenW-1:0] len_r;
  logic            nvm_r, big_r;
  logic [CW-1:0]   cnt_r;      // address issued
  logic            rv_r;       // read data valid for address cnt_r-1
  logic [LenW-1:0] small_lim_r, big_lim_r;
  logic            ov_r;
  logic [19:0]     ores_r;
  logic [19:0]     out_r;

  // Memory ports
  logic [SAW-1:0] s_ra, s_wa;
  logic [BAW-1:0] b_ra, b_wa;
  slot_t          s_rd, b_rd, wdat;
  logic           s_we, b_we;

  tksc_tier #(.Slots(SMALL_SLOTS)) u_small (
    .clk, .rst_n, .rd_addr(s_ra), .rd_data(s_rd),
    .wr_en(s_we), .wr_addr(s_wa), .wr_data(wdat));
  tksc_tier #(.Slots(BIG_SLOTS)) u_big (
    .clk, .rst_n, .rd_addr(b_ra), .rd_data(b_rd),
    .wr_en(b_we), .wr_addr(b_wa), .wr_data(wdat));

  // Configuration port
  assign cfg_pready = 1'b1;
  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == {REG_SMALL_LIMIT, 2'b00}) cfg_prdata[LenW-1:0] = small_lim_r;
    else if (cfg_paddr == {REG_BIG_LIMIT, 2'b00}) cfg_prdata[LenW-1:0] = big_lim_r;
  end

  // Scan addresses follow the counter; the tier being scanned depends on state
  logic scan_big;
  logic last_rd;
  logic [CW-1:0] n_cur;
  slot_t cur;
  logic [CW-1:0] idx;
  always_comb begin
    scan_big = (state_r == S_DUP) ? !big_r : big_r;
    n_cur    = scan_big ? CW'(BIG_SLOTS) : CW'(SMALL_SLOTS);
    cur      = scan_big ? b_rd : s_rd;
    idx      = cnt_r - CW'(1);
    last_rd  = rv_r && (idx == n_cur - CW'(1));
    s_ra     = cnt_r[SAW-1:0];
    b_ra     = cnt_r[BAW-1:0];
  end

  // Match conditions on the entry returned this cycle
  logic hit_free, hit_com, hit_id;
  assign hit_id   = (cur.id == id_r);
  assign hit_free = (cur.id[7:0] == 8'd0) || (kind_r == KIND_INSERT && hit_id);
  assign hit_com  = cur.com;

  // Write port and result
  logic [1:0] res_st;
  slot_t      res_e;
  logic       do_wr, wr_big, fin;
  always_comb begin
    do_wr  = 1'b0;
    wr_big = scan_big;
    wdat   = cur;
    res_st = ST_OK;
    res_e  = cur;
    fin    = 1'b0;
    unique case (state_r)
      S_DUP: begin
        if (rv_r && hit_id) begin
          do_wr   = 1'b1;
          wdat.id = '0;
        end
      end
      S_FREE, S_COM: begin
        if (rv_r && ((state_r == S_FREE) ? hit_free : hit_com)) begin
          do_wr = 1'b1;
          fin   = 1'b1;
          if (kind_r == KIND_INSERT) wdat = '{id: id_r, len: len_r, com: nvm_r};
          else wdat = '0;
          res_e = wdat;
        end else if (state_r == S_COM && last_rd) begin
          fin    = 1'b1;
          res_st = ST_NOSPACE;
        end
      end
      S_FIND: begin
        if (rv_r && hit_id) begin
          fin = 1'b1;
          if (kind_r == KIND_EVICT) begin
            do_wr = 1'b1;
            wdat.id = '0;
          end else if (kind_r == KIND_COMMIT) begin
            do_wr = 1'b1;
            wdat.com = 1'b1;
          end
          res_e = wdat;
        end else if (last_rd && scan_big) begin
          fin    = 1'b1;
          res_st = ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    s_we = do_wr && !wr_big;
    b_we = do_wr && wr_big;
    s_wa = idx[SAW-1:0];
    b_wa = idx[BAW-1:0];
  end

  // A held result sits in its own register, so the next request may start
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, out_r};

  logic [2:0]      in_kind;
  logic [IdW-1:0]  in_id;
  logic [LenW-1:0] in_len;
  logic            in_nvm;
  assign in_kind = in_tuser;
  assign in_id   = in_tdata[15:0];
  assign in_len  = in_tdata[28:16];
  assign in_nvm  = in_tdata[29];

  // Sequencer and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ov_r        <= 1'b0;
      rv_r        <= 1'b0;
      cnt_r       <= '0;
      small_lim_r <= SmallLimitRst;
      big_lim_r   <= BigLimitRst;
    end else begin
      if (cfg_wr && cfg_paddr[2] == REG_SMALL_LIMIT && cfg_paddr[1:0] == 2'd0)
        small_lim_r <= cfg_pwdata[LenW-1:0];
      if (cfg_wr && cfg_paddr[2] == REG_BIG_LIMIT && cfg_paddr[1:0] == 2'd0)
        big_lim_r <= cfg_pwdata[LenW-1:0];
      if (ov_r && out_tready) ov_r <= 1'b0;
      // Advance the scan: one read issued per cycle
      if (cnt_r < n_cur) begin
        cnt_r <= cnt_r + CW'(1);
        rv_r  <= 1'b1;
      end else begin
        rv_r  <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          rv_r  <= 1'b0;
          if (in_tvalid && in_tready) begin
            kind_r <= in_kind;
            id_r   <= in_id;
            len_r  <= in_len;
            nvm_r  <= in_nvm;
            big_r  <= in_len > small_lim_r;
            ores_r <= {18'd0, ST_BADARGS};
            if (in_kind == KIND_INSERT || in_kind == KIND_CLAIM) begin
              if ((in_len > small_lim_r && in_len > big_lim_r) ||
                  (in_kind == KIND_INSERT && in_id[7:0] == 8'd0))
                state_r <= S_DONE;
              else if (in_kind == KIND_INSERT) state_r <= S_DUP;
              else state_r <= S_FREE;
            end else if (in_kind == KIND_LOOKUP || in_kind == KIND_EVICT ||
                         in_kind == KIND_COMMIT) begin
              big_r   <= 1'b0;
              state_r <= (in_id[7:0] == 8'd0) ? S_DONE : S_FIND;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_DUP: begin
          // Stop at the first duplicate; only one is erased
          if ((rv_r && hit_id) || last_rd) begin
            state_r <= S_FREE;
            cnt_r   <= '0;
            rv_r    <= 1'b0;
          end
        end
        S_FREE, S_COM, S_FIND: begin
          if (fin) begin
            state_r <= S_DONE;
            if (res_st == ST_OK)
              ores_r <= {res_e.com, res_e.len, 3'(idx), scan_big, ST_OK};
            else
              ores_r <= {18'd0, res_st};
          end else if (last_rd) begin
            // Next pass: committed search, or the big tier for a find
            if (state_r == S_FREE) state_r <= S_COM;
            else big_r <= 1'b1;
            cnt_r <= '0;
            rv_r  <= 1'b0;
          end
        end
        S_DONE: begin
          // Wait until the output register is free or being emptied
          if (!ov_r || out_tready) begin
            ov_r    <= 1'b1;
            out_r   <= ores_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A stalled result word stays valid and unchanged
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> (ov_r && $stable(out_r)))
    else $error("result word changed while stalled");
  // The memories are written only while a request is being worked on
  assert property (@(posedge clk) disable iff (!rst_n)
    (s_we || b_we) |-> (state_r != S_IDLE && state_r != S_DONE))
    else $error("slot write outside a request");
  // Every failure result carries zero slot fields
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_r[1:0] != ST_OK) |-> (out_r[19:2] == 18'd0))
    else $error("failure result with slot data");

endmodule

>>> rtl/tksc_tier.sv
// One tier of slots: a synchronous memory with one read and one write port,
// plus a valid bit per entry so that an entry never written reads as zero.
module tksc_tier
  import tksc_pkg::*;
#(
  parameter int Slots = SmallSlotsDef,
  localparam int AW = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output slot_t         rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_t         wr_data
);

  slot_t             mem [Slots];
  slot_t             q_r;
  logic              qv_r;
  logic [Slots-1:0]  vld_r;

  // Memory array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_r <= mem[rd_addr];
  end

  // Valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      qv_r <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = qv_r ? q_r : '0;

endmodule

>>> dv/tb.sv
module tb;
  import tksc_pkg::*;

  localparam int NSMALL = 8;
  localparam int NBIG = 2;
  localparam int RANDOM_WORDS = 1330;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]      kind;
    logic [IdW-1:0]  key_id;
    logic [LenW-1:0] key_len;
    logic            nvm;
  } request_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            big;
    logic [2:0]      slot;
    logic [LenW-1:0] len;
    logic            com;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  two_tier_key_slot_cache_top u_dut (.*);

  // Predictor copy of the slot tables and limits.
  logic [IdW-1:0]  sm_id [NSMALL];
  logic [LenW-1:0] sm_len [NSMALL];
  logic            sm_com [NSMALL];
  logic [IdW-1:0]  bg_id [NBIG];
  logic [LenW-1:0] bg_len [NBIG];
  logic            bg_com [NBIG];
  logic [LenW-1:0] small_limit;
  logic [LenW-1:0] big_limit;

  request_t pending_words[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int cycles = 0;
  int in_wait = 0;
  int out_wait = 0;
  bit hold_req = 1'b0;
  logic stall = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit erased(logic [IdW-1:0] id);
    return id[7:0] == 8'd0;
  endfunction

  // Works out the answer to one request and updates the tables.
  function automatic answer_t cache_answer(request_t r);
    answer_t a;
    int s;
    bit isbig;
    a = '0;
    s = -1;
    if (r.kind == KIND_INSERT || r.kind == KIND_CLAIM) begin
      if ((r.key_len > small_limit && r.key_len > big_limit) ||
          (r.kind == KIND_INSERT && erased(r.key_id))) begin
        a.status = ST_BADARGS;
        return a;
      end
      isbig = r.key_len > small_limit;
      // An insert first drops a duplicate from the other tier.
      if (r.kind == KIND_INSERT) begin
        if (!isbig) begin
          for (int i = 0; i < NBIG; i++)
            if (bg_id[i] == r.key_id) begin bg_id[i] = '0; break; end
        end else begin
          for (int i = 0; i < NSMALL; i++)
            if (sm_id[i] == r.key_id) begin sm_id[i] = '0; break; end
        end
      end
      for (int i = 0; i < (isbig ? NBIG : NSMALL); i++) begin
        logic [IdW-1:0] cur;
        cur = isbig ? bg_id[i] : sm_id[i];
        if (erased(cur) || (r.kind == KIND_INSERT && cur == r.key_id)) begin
          s = i;
          break;
        end
      end
      if (s < 0)
        for (int i = 0; i < (isbig ? NBIG : NSMALL); i++)
          if (isbig ? bg_com[i] : sm_com[i]) begin s = i; break; end
      if (s < 0) begin
        a.status = ST_NOSPACE;
        return a;
      end
      if (isbig) begin
        bg_id[s] = r.kind == KIND_INSERT ? r.key_id : '0;
        bg_len[s] = r.kind == KIND_INSERT ? r.key_len : '0;
        bg_com[s] = r.kind == KIND_INSERT ? r.nvm : 1'b0;
      end else begin
        sm_id[s] = r.kind == KIND_INSERT ? r.key_id : '0;
        sm_len[s] = r.kind == KIND_INSERT ? r.key_len : '0;
        sm_com[s] = r.kind == KIND_INSERT ? r.nvm : 1'b0;
      end
    end else begin
      if (r.kind > KIND_CLAIM || erased(r.key_id)) begin
        a.status = ST_BADARGS;
        return a;
      end
      isbig = 1'b0;
      for (int i = 0; i < NSMALL; i++)
        if (sm_id[i] == r.key_id) begin s = i; break; end
      if (s < 0)
        for (int i = 0; i < NBIG; i++)
          if (bg_id[i] == r.key_id) begin s = i; isbig = 1'b1; break; end
      if (s < 0) begin
        a.status = ST_NOTFOUND;
        return a;
      end
      if (r.kind == KIND_EVICT) begin
        if (isbig) bg_id[s] = '0; else sm_id[s] = '0;
      end else if (r.kind == KIND_COMMIT) begin
        if (isbig) bg_com[s] = 1'b1; else sm_com[s] = 1'b1;
      end
    end
    a.status = ST_OK;
    a.big = isbig;
    a.slot = s[2:0];
    a.len = isbig ? bg_len[s] : sm_len[s];
    a.com = isbig ? bg_com[s] : sm_com[s];
    return a;
  endfunction

  // Driver: offers pending words with random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_answers.push_back(cache_answer(request_t'({in_tuser,
            in_tdata[15:0], in_tdata[28:16], in_tdata[29]})));
        void'(pending_words.pop_front());
        in_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      end
      if (in_wait > 0) begin
        in_wait--;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {2'b00, pending_words[0].nvm, pending_words[0].key_len,
                     pending_words[0].key_id};
        in_tuser <= pending_words[0].kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver stall, counted in cycles here once requested.
  initial begin
    wait (hold_req);
    @(posedge clk);
    stall <= 1'b1;
    repeat (300) @(posedge clk);
    stall <= 1'b0;
  end

  // Monitor: checks each result word and stalls at random.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h", $time, out_tdata);
          errors++;
        end else begin
          answer_t e;
          answer_t g;
          e = expected_answers.pop_front();
          g.status = out_tdata[1:0];
          g.big = out_tdata[2];
          g.slot = out_tdata[5:3];
          g.len = out_tdata[18:6];
          g.com = out_tdata[19];
          if (g.status !== e.status || g.big !== e.big || g.slot !== e.slot ||
              g.len !== e.len || g.com !== e.com) begin
            $display("%0t: mismatch, expected st%0d big%0d slot%0d len%0d com%0d, got st%0d big%0d slot%0d len%0d com%0d",
                     $time, e.status, e.big, e.slot, e.len, e.com,
                     g.status, g.big, g.slot, g.len, g.com);
            errors++;
          end
        end
        out_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      end
      if (stall) begin
        out_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_limit(input logic idx, input logic [LenW-1:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {19'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_SMALL_LIMIT) small_limit = v; else big_limit = v;
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_answers.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic request_t make_req(logic [2:0] k, logic [IdW-1:0] id,
                                       logic [LenW-1:0] l, logic n);
    request_t r;
    r.kind = k; r.key_id = id; r.key_len = l; r.nvm = n;
    return r;
  endfunction

  // Draws a random request, mostly over a small pool of ids to cause hits.
  function automatic request_t random_req();
    request_t r;
    int p;
    p = $urandom_range(0, 99);
    r.kind = p < 35 ? KIND_INSERT : p < 50 ? KIND_LOOKUP : p < 62 ? KIND_EVICT :
             p < 77 ? KIND_COMMIT : p < 93 ? KIND_CLAIM : 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) < 8)
      r.key_id = {8'($urandom_range(0, 1) * $urandom_range(0, 255)),
                  8'($urandom_range(0, 12))};
    else
      r.key_id = 16'($urandom);
    p = $urandom_range(0, 9);
    r.key_len = p < 5 ? 13'($urandom_range(0, 300)) : p < 9 ?
                13'($urandom_range(0, 1100)) : 13'($urandom_range(0, 8191));
    r.nvm = 1'($urandom);
    return r;
  endfunction

  initial begin
    for (int i = 0; i < NSMALL; i++) begin
      sm_id[i] = '0; sm_len[i] = '0; sm_com[i] = 1'b0;
    end
    for (int i = 0; i < NBIG; i++) begin
      bg_id[i] = '0; bg_len[i] = '0; bg_com[i] = 1'b0;
    end
    small_limit = SmallLimitRst;
    big_limit = BigLimitRst;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: erased ids, unknown kinds, oversize keys, tier fill and spill.
    pending_words.push_back(make_req(KIND_INSERT, 16'h0100, 13'd5, 1'b0));
    pending_words.push_back(make_req(3'd5, 16'h0001, 13'd0, 1'b0));
    pending_words.push_back(make_req(3'd7, 16'hFFFF, 13'h1FFF, 1'b1));
    pending_words.push_back(make_req(KIND_INSERT, 16'hFFFF, 13'h1FFF, 1'b1));
    pending_words.push_back(make_req(KIND_LOOKUP, 16'h0042, 13'd0, 1'b0));
    pending_words.push_back(make_req(KIND_LOOKUP, 16'hAB00, 13'd0, 1'b0));
    for (int i = 1; i <= 9; i++)
      pending_words.push_back(make_req(KIND_INSERT, 16'(i), 13'(i), 1'b0));
    pending_words.push_back(make_req(KIND_COMMIT, 16'd3, 13'd0, 1'b0));
    pending_words.push_back(make_req(KIND_INSERT, 16'd9, 13'd256, 1'b1));
    pending_words.push_back(make_req(KIND_INSERT, 16'd20, 13'd1024, 1'b1));
    pending_words.push_back(make_req(KIND_INSERT, 16'd21, 13'd900, 1'b0));
    pending_words.push_back(make_req(KIND_INSERT, 16'd22, 13'd257, 1'b0));
    pending_words.push_back(make_req(KIND_INSERT, 16'd20, 13'd10, 1'b0));
    pending_words.push_back(make_req(KIND_CLAIM, 16'd0, 13'd1025, 1'b0));
    pending_words.push_back(make_req(KIND_CLAIM, 16'd0, 13'd300, 1'b0));
    pending_words.push_back(make_req(KIND_EVICT, 16'd2, 13'd0, 1'b0));
    pending_words.push_back(make_req(KIND_LOOKUP, 16'd21, 13'd0, 1'b0));
    wait_drained();

    // Random phases over several limit settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_limit(REG_SMALL_LIMIT, 13'd0); write_limit(REG_BIG_LIMIT, 13'd4096); end
        1: begin write_limit(REG_SMALL_LIMIT, 13'd4096); write_limit(REG_BIG_LIMIT, 13'd0); end
        2: begin write_limit(REG_SMALL_LIMIT, 13'd0); write_limit(REG_BIG_LIMIT, 13'd0); end
        3: begin write_limit(REG_SMALL_LIMIT, 13'h1FFF); write_limit(REG_BIG_LIMIT, 13'h1FFF); end
        4: begin
          write_limit(REG_SMALL_LIMIT, 13'($urandom_range(0, 600)));
          write_limit(REG_BIG_LIMIT, 13'($urandom_range(0, 1200)));
        end
        default: begin write_limit(REG_SMALL_LIMIT, 13'd256); write_limit(REG_BIG_LIMIT, 13'd1024); end
      endcase
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < RANDOM_WORDS / 6; i++) pending_words.push_back(random_req());
      wait_drained();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> two_tier_key_slot_cache_top.f
rtl/tksc_pkg.sv
rtl/tksc_tier.sv
rtl/two_tier_key_slot_cache_top.sv
dv/tb.sv
